// File: rtl/ssup_pkg.sv
// ----------------------------------------------------------------------------
// ssup_pkg
// Shared constants, register indexes and the command item type for the
// supersampled sprite blit.
// ----------------------------------------------------------------------------
package ssup_pkg;

  localparam int MAX_SRC_DIM     = 128;
  localparam int COORD_BITS      = 12;
  localparam int FRAC_BITS       = 12;
  localparam int TEXEL_ADDR_BITS = 14;
  localparam int COLOR_BITS      = 32;
  localparam int CHAN_BITS       = 8;
  localparam int NUM_CHAN        = COLOR_BITS / CHAN_BITS;
  localparam int CHAN_SUM_BITS   = CHAN_BITS + 2;
  localparam int NUM_SAMPLES     = 4;
  localparam int STEP_BITS       = $clog2(NUM_SAMPLES);

  localparam int DIM_BITS        = $clog2(MAX_SRC_DIM + 1);
  localparam int DIM_IDX_BITS    = $clog2(MAX_SRC_DIM);
  localparam int STORE_DEPTH     = MAX_SRC_DIM * MAX_SRC_DIM;
  localparam int ADDR_BITS       = $clog2(STORE_DEPTH);

  localparam int REG_BITS        = 8;
  localparam int POS_BITS        = 17;
  localparam int SCALE_BITS      = 16;
  localparam int CFG_DATA_BITS   = 17;
  localparam int CFG_INDEX_BITS  = 3;

  localparam int PIX_EXT_BITS    = COORD_BITS + 4;
  localparam int LOCAL_BITS      = ((PIX_EXT_BITS > POS_BITS) ? PIX_EXT_BITS : POS_BITS) + 2;
  localparam int PROD_BITS       = LOCAL_BITS + SCALE_BITS + 1;
  localparam int IDX_BITS        = PROD_BITS - 1 - FRAC_BITS;

  localparam int OFF_LO          = 4;
  localparam int OFF_STEP_SHIFT  = 3;

  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);
  localparam int CREDIT_BITS     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_INDEX_BITS-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_POS_X      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_POS_Y      = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INV_SCALE  = 3'd4;

  localparam logic [REG_BITS-1:0]   SRC_DIM_RESET   = 8'd128;
  localparam logic [SCALE_BITS-1:0] INV_SCALE_RESET = 16'd256;

  typedef struct packed {
    logic                                  shade;
    logic                                  wr_ok;
    logic [ADDR_BITS-1:0]                  wr_addr;
    logic [COLOR_BITS-1:0]                 wr_data;
    logic [NUM_SAMPLES-1:0][ADDR_BITS-1:0] addr;
    logic [NUM_SAMPLES-1:0]                hit;
    logic [COORD_BITS-1:0]                 px;
    logic [COORD_BITS-1:0]                 py;
  } cmd_t;

endpackage

// File: rtl/scaled_sprite_supersample.sv
// ----------------------------------------------------------------------------
// scaled_sprite_supersample
// Throughput: a shade item holds the store port for its four sample reads;
// one load item every cycle while no shade item holds the port; both are set
// by the single port of the source image store.
// Reset: synchronous; clears registers to their defaults and empties the
// queue; the image store is not cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
module scaled_sprite_supersample (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  kind,
  input  logic [ssup_pkg::TEXEL_ADDR_BITS-1:0]  texel_addr,
  input  logic [ssup_pkg::COLOR_BITS-1:0]       texel_color,
  input  logic [ssup_pkg::COORD_BITS-1:0]       pixel_x,
  input  logic [ssup_pkg::COORD_BITS-1:0]       pixel_y,
  input  logic                                  wr_en,
  input  logic [ssup_pkg::CFG_INDEX_BITS-1:0]   wr_index,
  input  logic [ssup_pkg::CFG_DATA_BITS-1:0]    wr_data,
  output logic                                  done,
  output logic [ssup_pkg::COLOR_BITS-1:0]       color,
  output logic [ssup_pkg::COORD_BITS-1:0]       out_x,
  output logic [ssup_pkg::COORD_BITS-1:0]       out_y
);

  ssup_pkg::cmd_t q_in;
  ssup_pkg::cmd_t q_out;
  logic           q_push;
  logic           q_pop;
  logic           q_empty;

  ssup_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .texel_addr  (texel_addr),
    .texel_color (texel_color),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .pop         (q_pop),
    .push        (q_push),
    .cmd         (q_in)
  );

  ssup_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  ssup_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (q_out),
    .empty (q_empty),
    .pop   (q_pop),
    .done  (done),
    .color (color),
    .out_x (out_x),
    .out_y (out_y)
  );

endmodule

// File: rtl/ssup_front.sv
// ----------------------------------------------------------------------------
// ssup_front
// Accepts items, holds configuration, scales the four sample points and
// resolves them to store addresses and inside flags.
// ----------------------------------------------------------------------------
module ssup_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   kind,
  input  logic [ssup_pkg::TEXEL_ADDR_BITS-1:0]   texel_addr,
  input  logic [ssup_pkg::COLOR_BITS-1:0]        texel_color,
  input  logic [ssup_pkg::COORD_BITS-1:0]        pixel_x,
  input  logic [ssup_pkg::COORD_BITS-1:0]        pixel_y,
  input  logic                                   wr_en,
  input  logic [ssup_pkg::CFG_INDEX_BITS-1:0]    wr_index,
  input  logic [ssup_pkg::CFG_DATA_BITS-1:0]     wr_data,
  input  logic                                   pop,
  output logic                                   push,
  output ssup_pkg::cmd_t                         cmd
);

  localparam int PB = ssup_pkg::PROD_BITS;
  localparam int LB = ssup_pkg::LOCAL_BITS;
  localparam int AB = ssup_pkg::ADDR_BITS;

  logic [ssup_pkg::REG_BITS-1:0]          src_width;
  logic [ssup_pkg::REG_BITS-1:0]          src_height;
  logic signed [ssup_pkg::POS_BITS-1:0]   pos_x;
  logic signed [ssup_pkg::POS_BITS-1:0]   pos_y;
  logic [ssup_pkg::SCALE_BITS-1:0]        inv_scale;
  logic [ssup_pkg::CREDIT_BITS-1:0]       in_flight;

  logic [ssup_pkg::DIM_BITS-1:0]          lim_w;
  logic [ssup_pkg::DIM_BITS-1:0]          lim_h;
  logic                                   accept;
  logic signed [LB-1:0]                   loc_x;
  logic signed [LB-1:0]                   loc_y;
  logic signed [PB-1:0]                   step_off;

  logic                                   a_valid;
  logic                                   a_shade;
  logic                                   a_wr_ok;
  logic [AB-1:0]                          a_wr_addr;
  logic [ssup_pkg::COLOR_BITS-1:0]        a_wr_data;
  logic [ssup_pkg::COORD_BITS-1:0]        a_px;
  logic [ssup_pkg::COORD_BITS-1:0]        a_py;
  logic signed [PB-1:0]                   a_prod_x;
  logic signed [PB-1:0]                   a_prod_y;
  logic signed [PB-1:0]                   a_prod_xb;
  logic signed [PB-1:0]                   a_prod_yb;

  logic                                   b_valid;
  logic                                   b_shade;
  logic                                   b_wr_ok;
  logic [AB-1:0]                          b_wr_addr;
  logic [ssup_pkg::COLOR_BITS-1:0]        b_wr_data;
  logic [ssup_pkg::COORD_BITS-1:0]        b_px;
  logic [ssup_pkg::COORD_BITS-1:0]        b_py;
  logic [1:0][ssup_pkg::DIM_IDX_BITS-1:0] b_tx;
  logic [1:0][ssup_pkg::DIM_IDX_BITS-1:0] b_ty;
  logic [1:0]                             b_inx;
  logic [1:0]                             b_iny;

  logic [1:0][AB:0]                       row_base;

  function automatic logic in_range(input logic signed [PB-1:0] p,
                                    input logic [ssup_pkg::DIM_BITS-1:0] lim);
    return !p[PB-1] && (p[PB-2:ssup_pkg::FRAC_BITS] < ssup_pkg::IDX_BITS'(lim));
  endfunction

  assign busy   = (in_flight == ssup_pkg::CREDIT_BITS'(ssup_pkg::QUEUE_DEPTH));
  assign accept = start && !busy;

  assign lim_w = (src_width > ssup_pkg::MAX_SRC_DIM) ?
                 ssup_pkg::DIM_BITS'(ssup_pkg::MAX_SRC_DIM) : ssup_pkg::DIM_BITS'(src_width);
  assign lim_h = (src_height > ssup_pkg::MAX_SRC_DIM) ?
                 ssup_pkg::DIM_BITS'(ssup_pkg::MAX_SRC_DIM) : ssup_pkg::DIM_BITS'(src_height);

  assign loc_x = $signed(LB'({pixel_x, 4'b0000})) - LB'(pos_x) + LB'(ssup_pkg::OFF_LO);
  assign loc_y = $signed(LB'({pixel_y, 4'b0000})) - LB'(pos_y) + LB'(ssup_pkg::OFF_LO);
  assign step_off = $signed(PB'({inv_scale, ssup_pkg::OFF_STEP_SHIFT'(0)}));

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= ssup_pkg::SRC_DIM_RESET;
      src_height <= ssup_pkg::SRC_DIM_RESET;
      pos_x      <= '0;
      pos_y      <= '0;
      inv_scale  <= ssup_pkg::INV_SCALE_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        ssup_pkg::REG_SRC_WIDTH:  src_width  <= wr_data[ssup_pkg::REG_BITS-1:0];
        ssup_pkg::REG_SRC_HEIGHT: src_height <= wr_data[ssup_pkg::REG_BITS-1:0];
        ssup_pkg::REG_POS_X:      pos_x      <= $signed(wr_data[ssup_pkg::POS_BITS-1:0]);
        ssup_pkg::REG_POS_Y:      pos_y      <= $signed(wr_data[ssup_pkg::POS_BITS-1:0]);
        ssup_pkg::REG_INV_SCALE:  inv_scale  <= wr_data[ssup_pkg::SCALE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // credits: items inside the front stages or the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else if (accept && !pop) begin
      in_flight <= in_flight + 1'b1;
    end else if (!accept && pop) begin
      in_flight <= in_flight - 1'b1;
    end
  end

  // stage A: scale the sample points
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept;
    end
    a_shade   <= kind;
    a_wr_ok   <= (32'(texel_addr) < ssup_pkg::STORE_DEPTH);
    a_wr_addr <= AB'(texel_addr);
    a_wr_data <= texel_color;
    a_px      <= pixel_x;
    a_py      <= pixel_y;
    a_prod_x  <= loc_x * $signed({1'b0, inv_scale});
    a_prod_y  <= loc_y * $signed({1'b0, inv_scale});
  end

  assign a_prod_xb = a_prod_x + step_off;
  assign a_prod_yb = a_prod_y + step_off;

  // stage B: truncate to texel indexes and test the image bounds
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_shade   <= a_shade;
    b_wr_ok   <= a_wr_ok;
    b_wr_addr <= a_wr_addr;
    b_wr_data <= a_wr_data;
    b_px      <= a_px;
    b_py      <= a_py;
    b_tx[0]   <= a_prod_x[ssup_pkg::FRAC_BITS +: ssup_pkg::DIM_IDX_BITS];
    b_tx[1]   <= a_prod_xb[ssup_pkg::FRAC_BITS +: ssup_pkg::DIM_IDX_BITS];
    b_ty[0]   <= a_prod_y[ssup_pkg::FRAC_BITS +: ssup_pkg::DIM_IDX_BITS];
    b_ty[1]   <= a_prod_yb[ssup_pkg::FRAC_BITS +: ssup_pkg::DIM_IDX_BITS];
    b_inx[0]  <= in_range(a_prod_x, lim_w);
    b_inx[1]  <= in_range(a_prod_xb, lim_w);
    b_iny[0]  <= in_range(a_prod_y, lim_h);
    b_iny[1]  <= in_range(a_prod_yb, lim_h);
  end

  // stage C: form store addresses, push into the queue
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      row_base[j] = (AB+1)'(b_ty[j]) * (AB+1)'(lim_w);
    end
    cmd.shade   = b_shade;
    cmd.wr_ok   = b_wr_ok;
    cmd.wr_addr = b_wr_addr;
    cmd.wr_data = b_wr_data;
    cmd.px      = b_px;
    cmd.py      = b_py;
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        cmd.addr[i*2+j] = AB'(row_base[j] + (AB+1)'(b_tx[i]));
        cmd.hit[i*2+j]  = b_inx[i] && b_iny[j];
      end
    end
  end

  assign push = b_valid;

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    in_flight <= ssup_pkg::CREDIT_BITS'(ssup_pkg::QUEUE_DEPTH))
    else $error("credit count above queue depth");

endmodule

// File: rtl/ssup_queue.sv
// ----------------------------------------------------------------------------
// ssup_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module ssup_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ssup_pkg::cmd_t din,
  input  logic           pop,
  output ssup_pkg::cmd_t dout,
  output logic           empty
);

  ssup_pkg::cmd_t                     slots [ssup_pkg::QUEUE_DEPTH];
  logic [ssup_pkg::QPTR_BITS-1:0]     wr_ptr;
  logic [ssup_pkg::QPTR_BITS-1:0]     rd_ptr;
  logic [ssup_pkg::CREDIT_BITS-1:0]   count;
  logic                               full;

  assign empty = (count == '0);
  assign full  = (count == ssup_pkg::CREDIT_BITS'(ssup_pkg::QUEUE_DEPTH));
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");

endmodule

// File: rtl/ssup_back.sv
// ----------------------------------------------------------------------------
// ssup_back
// Owns the source image store: writes loaded texels, reads the four samples
// of a shade item and averages them per channel.
// ----------------------------------------------------------------------------
module ssup_back (
  input  logic                              clk,
  input  logic                              rst,
  input  ssup_pkg::cmd_t                    head,
  input  logic                              empty,
  output logic                              pop,
  output logic                              done,
  output logic [ssup_pkg::COLOR_BITS-1:0]   color,
  output logic [ssup_pkg::COORD_BITS-1:0]   out_x,
  output logic [ssup_pkg::COORD_BITS-1:0]   out_y
);

  localparam int SB = ssup_pkg::CHAN_SUM_BITS;

  logic [ssup_pkg::COLOR_BITS-1:0]   store [ssup_pkg::STORE_DEPTH];
  logic [ssup_pkg::COLOR_BITS-1:0]   rdata;

  ssup_pkg::cmd_t                    cur;
  logic                              cur_valid;
  logic [ssup_pkg::STEP_BITS-1:0]    step;
  logic                              advance;
  logic                              mem_we;
  logic [ssup_pkg::ADDR_BITS-1:0]    mem_addr;

  logic                              rd_valid;
  logic                              rd_first;
  logic                              rd_last;
  logic                              rd_hit;
  logic [ssup_pkg::COORD_BITS-1:0]   rd_px;
  logic [ssup_pkg::COORD_BITS-1:0]   rd_py;

  logic [ssup_pkg::NUM_CHAN-1:0][SB-1:0]             acc;
  logic [ssup_pkg::NUM_CHAN-1:0][SB-1:0]             sum;
  logic [ssup_pkg::COLOR_BITS-1:0]                   sample;
  logic [ssup_pkg::COLOR_BITS-1:0]                   avg;

  assign advance  = !cur_valid || !cur.shade ||
                    (step == ssup_pkg::STEP_BITS'(ssup_pkg::NUM_SAMPLES - 1));
  assign pop      = advance && !empty;
  assign mem_we   = cur_valid && !cur.shade && cur.wr_ok;
  assign mem_addr = cur.shade ? cur.addr[step] : cur.wr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= '0;
    end else if (advance) begin
      cur_valid <= pop;
      step      <= '0;
    end else begin
      step      <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_addr] <= cur.wr_data;
    end
    rdata <= store[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      rd_first <= 1'b0;
      rd_last  <= 1'b0;
    end else begin
      rd_valid <= cur_valid && cur.shade;
      rd_first <= (step == '0);
      rd_last  <= cur_valid && cur.shade &&
                  (step == ssup_pkg::STEP_BITS'(ssup_pkg::NUM_SAMPLES - 1));
    end
    rd_hit <= cur.hit[step];
    rd_px  <= cur.px;
    rd_py  <= cur.py;
  end

  always_comb begin
    sample = rd_hit ? rdata : '0;
    for (int c = 0; c < ssup_pkg::NUM_CHAN; c++) begin
      sum[c] = (rd_first ? SB'(0) : acc[c]) +
               SB'(sample[c*ssup_pkg::CHAN_BITS +: ssup_pkg::CHAN_BITS]);
      avg[c*ssup_pkg::CHAN_BITS +: ssup_pkg::CHAN_BITS] = sum[c][SB-1:2];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      acc <= sum;
    end
    if (rd_last) begin
      color <= avg;
      out_x <= rd_px;
      out_y <= rd_py;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= rd_last;
    end
  end

  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(rd_valid && rd_last))
    else $error("result strobe without a final sample read");

  a_no_write_in_shade: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> !rd_valid)
    else $error("store write overlapped a sample read");

endmodule

// File: dv/ssup_tb_pkg.sv
// ----------------------------------------------------------------------------
// ssup_tb_pkg
// Command kind codes shared by the checker and the testbench top of the
// supersampled sprite blit, and a spare register index for the testbench top.
// ----------------------------------------------------------------------------
package ssup_tb_pkg;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_SHADE = 1'b1;

  localparam logic [ssup_pkg::CFG_INDEX_BITS-1:0] REG_SPARE = 3'd6;

endpackage

// File: dv/ssup_checker.sv
// ----------------------------------------------------------------------------
// ssup_checker
// Watches the command, register and result ports of the sprite blit. Keeps
// its own copy of the source image and registers, works out the averaged
// color of every accepted shade item and compares each result in order.
// ----------------------------------------------------------------------------
module ssup_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic                                  busy,
  input  logic                                  kind,
  input  logic [ssup_pkg::TEXEL_ADDR_BITS-1:0]  texel_addr,
  input  logic [ssup_pkg::COLOR_BITS-1:0]       texel_color,
  input  logic [ssup_pkg::COORD_BITS-1:0]       pixel_x,
  input  logic [ssup_pkg::COORD_BITS-1:0]       pixel_y,
  input  logic                                  wr_en,
  input  logic [ssup_pkg::CFG_INDEX_BITS-1:0]   wr_index,
  input  logic [ssup_pkg::CFG_DATA_BITS-1:0]    wr_data,
  input  logic                                  done,
  input  logic [ssup_pkg::COLOR_BITS-1:0]       color,
  input  logic [ssup_pkg::COORD_BITS-1:0]       out_x,
  input  logic [ssup_pkg::COORD_BITS-1:0]       out_y,
  output int                                    fail_count,
  output int                                    pending
);
  import ssup_pkg::*;
  import ssup_tb_pkg::*;

  typedef struct packed {
    logic [COLOR_BITS-1:0] color;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } shade_result_t;

  localparam longint NEAR_OFF = 4;
  localparam longint FAR_OFF  = 12;

  logic [COLOR_BITS-1:0]      image [STORE_DEPTH];
  logic [REG_BITS-1:0]        src_w;
  logic [REG_BITS-1:0]        src_h;
  logic signed [POS_BITS-1:0] org_x;
  logic signed [POS_BITS-1:0] org_y;
  logic [SCALE_BITS-1:0]      inv_scale;
  shade_result_t              colors_due[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic longint scaled_coord(logic [COORD_BITS-1:0] pix,
                                          logic signed [POS_BITS-1:0] org, longint off);
    return (longint'(pix) * 16 - longint'(org) + off) * longint'(inv_scale);
  endfunction

  function automatic logic [COLOR_BITS-1:0] texel_at(longint sx, longint sy);
    longint w;
    longint h;
    longint tx;
    longint ty;
    w = (src_w > MAX_SRC_DIM) ? MAX_SRC_DIM : src_w;
    h = (src_h > MAX_SRC_DIM) ? MAX_SRC_DIM : src_h;
    if (sx < 0 || sy < 0) return '0;
    tx = sx >>> FRAC_BITS;
    ty = sy >>> FRAC_BITS;
    if (tx >= w || ty >= h) return '0;
    return image[ty * w + tx];
  endfunction

  function automatic logic [COLOR_BITS-1:0] blend_pixel(logic [COORD_BITS-1:0] px,
                                                        logic [COORD_BITS-1:0] py);
    logic [COLOR_BITS-1:0] taps [NUM_SAMPLES];
    logic [COLOR_BITS-1:0] mix;
    longint xa;
    longint xb;
    longint ya;
    longint yb;
    int sum;
    xa = scaled_coord(px, org_x, NEAR_OFF);
    xb = scaled_coord(px, org_x, FAR_OFF);
    ya = scaled_coord(py, org_y, NEAR_OFF);
    yb = scaled_coord(py, org_y, FAR_OFF);
    taps[0] = texel_at(xa, ya);
    taps[1] = texel_at(xa, yb);
    taps[2] = texel_at(xb, ya);
    taps[3] = texel_at(xb, yb);
    mix = '0;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      sum = 0;
      for (int s = 0; s < NUM_SAMPLES; s++) sum += taps[s][ch*CHAN_BITS +: CHAN_BITS];
      mix[ch*CHAN_BITS +: CHAN_BITS] = CHAN_BITS'(sum / NUM_SAMPLES);
    end
    return mix;
  endfunction

  always @(posedge clk) begin
    shade_result_t due;
    if (rst) begin
      src_w     = SRC_DIM_RESET;
      src_h     = SRC_DIM_RESET;
      org_x     = '0;
      org_y     = '0;
      inv_scale = INV_SCALE_RESET;
      colors_due.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_SRC_WIDTH:  src_w     = wr_data[REG_BITS-1:0];
          REG_SRC_HEIGHT: src_h     = wr_data[REG_BITS-1:0];
          REG_POS_X:      org_x     = wr_data[POS_BITS-1:0];
          REG_POS_Y:      org_y     = wr_data[POS_BITS-1:0];
          REG_INV_SCALE:  inv_scale = wr_data[SCALE_BITS-1:0];
          default: ;
        endcase
      end
      if (done) begin
        if (colors_due.size() == 0) begin
          $display("%0t unexpected result: expected none, actual color %h x %0d y %0d",
                   $time, color, out_x, out_y);
          fail_count++;
        end else begin
          due = colors_due.pop_front();
          if (color !== due.color) begin
            $display("%0t color: expected %h actual %h", $time, due.color, color);
            fail_count++;
          end
          if (out_x !== due.x) begin
            $display("%0t out_x: expected %0d actual %0d", $time, due.x, out_x);
            fail_count++;
          end
          if (out_y !== due.y) begin
            $display("%0t out_y: expected %0d actual %0d", $time, due.y, out_y);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        if (kind == KIND_SHADE) begin
          colors_due.push_back('{blend_pixel(pixel_x, pixel_y), pixel_x, pixel_y});
        end else begin
          image[texel_addr] = texel_color;
        end
      end
    end
    pending = colors_due.size();
  end

endmodule

// File: dv/tb_scaled_sprite_supersample.sv
// ----------------------------------------------------------------------------
// tb_scaled_sprite_supersample
// Fills the low part of the source image, runs a short directed set of shade
// items at the coordinate extremes and special register values, then random
// load and shade items over a series of register settings with varying sender
// gaps. Every setting keeps the image small enough that shade items only read
// filled texels. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_scaled_sprite_supersample;
  import ssup_pkg::*;
  import ssup_tb_pkg::*;

  localparam int HALF_PERIOD       = 10;
  localparam int RESET_CYCLES      = 9;
  localparam int SETTLE_CYCLES     = 16;
  localparam int WATCHDOG_LIMIT    = 2000;
  localparam int NUM_SETTINGS      = 9;
  localparam int ITEMS_PER_SETTING = 120;
  localparam int FILL_DEPTH        = 512;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic                       kind;
  logic [TEXEL_ADDR_BITS-1:0] texel_addr;
  logic [COLOR_BITS-1:0]      texel_color;
  logic [COORD_BITS-1:0]      pixel_x;
  logic [COORD_BITS-1:0]      pixel_y;
  logic                       wr_en;
  logic [CFG_INDEX_BITS-1:0]  wr_index;
  logic [CFG_DATA_BITS-1:0]   wr_data;
  logic                       done;
  logic [COLOR_BITS-1:0]      color;
  logic [COORD_BITS-1:0]      out_x;
  logic [COORD_BITS-1:0]      out_y;

  int fail_count;
  int pending;
  int idle_pct  = 0;
  int stall_run = 0;

  logic [REG_BITS-1:0]        cur_w;
  logic [REG_BITS-1:0]        cur_h;
  logic signed [POS_BITS-1:0] cur_x;
  logic signed [POS_BITS-1:0] cur_y;
  logic [SCALE_BITS-1:0]      cur_inv;

  scaled_sprite_supersample u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .texel_addr  (texel_addr),
    .texel_color (texel_color),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .done        (done),
    .color       (color),
    .out_x       (out_x),
    .out_y       (out_y)
  );

  ssup_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .texel_addr  (texel_addr),
    .texel_color (texel_color),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .done        (done),
    .color       (color),
    .out_x       (out_x),
    .out_y       (out_y),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || done || wr_en || (start && !busy)) begin
      stall_run <= 0;
    end else if (stall_run >= WATCHDOG_LIMIT) begin
      $display("tb_scaled_sprite_supersample NOT OK");
      $finish;
    end else begin
      stall_run <= stall_run + 1;
    end
  end

  task automatic send_item(logic k, logic [31:0] addr, logic [31:0] c,
                           logic [31:0] x, logic [31:0] y);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start       <= 1'b1;
    kind        <= k;
    texel_addr  <= addr[TEXEL_ADDR_BITS-1:0];
    texel_color <= c;
    pixel_x     <= x[COORD_BITS-1:0];
    pixel_y     <= y[COORD_BITS-1:0];
    do @(posedge clk); while (busy);
  endtask

  task automatic load_texel(logic [31:0] addr, logic [31:0] c);
    send_item(KIND_LOAD, addr, c, $urandom, $urandom);
  endtask

  task automatic shade_pixel(logic [31:0] x, logic [31:0] y);
    send_item(KIND_SHADE, $urandom, $urandom, x, y);
  endtask

  task automatic wait_results();
    @(negedge clk);
    start <= 1'b0;
    wait (pending == 0);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(negedge clk);
    wr_en    <= 1'b0;
  endtask

  task automatic apply_setting(logic [REG_BITS-1:0] w, logic [REG_BITS-1:0] h,
                               logic [POS_BITS-1:0] ox, logic [POS_BITS-1:0] oy,
                               logic [SCALE_BITS-1:0] inv);
    logic [31:0] junk;
    junk = $urandom;
    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(REG_SRC_WIDTH, {junk[8:0], w});
    write_reg(REG_SRC_HEIGHT, {junk[17:9], h});
    write_reg(REG_POS_X, ox);
    write_reg(REG_POS_Y, oy);
    write_reg(REG_INV_SCALE, {junk[18], inv});
    write_reg(REG_SPARE, junk[31:15]);
    cur_w   = w;
    cur_h   = h;
    cur_x   = ox;
    cur_y   = oy;
    cur_inv = inv;
  endtask

  // aim near the sprite so that most samples land inside the image
  function automatic logic [31:0] aim_coord(logic signed [POS_BITS-1:0] org,
                                            logic [REG_BITS-1:0] dim);
    int d;
    int span;
    int p;
    d    = (dim > MAX_SRC_DIM) ? MAX_SRC_DIM : dim;
    span = (d * 256) / ((cur_inv == 0) ? 1 : int'(cur_inv)) + 2;
    p    = (int'(org) >>> 4) + int'($urandom_range(span)) - 1;
    if (p < 0) p = 0;
    if (p > 4095) p = 4095;
    return p;
  endfunction

  task automatic random_item();
    if ($urandom_range(3) == 0) begin
      load_texel($urandom, $urandom);
    end else if ($urandom_range(9) < 7) begin
      shade_pixel(aim_coord(cur_x, cur_w), aim_coord(cur_y, cur_h));
    end else begin
      shade_pixel($urandom, $urandom);
    end
  endtask

  initial begin
    int rx;
    int ry;
    rst         = 1'b1;
    start       = 1'b0;
    kind        = KIND_LOAD;
    texel_addr  = '0;
    texel_color = '0;
    pixel_x     = '0;
    pixel_y     = '0;
    wr_en       = 1'b0;
    wr_index    = REG_SRC_WIDTH;
    wr_data     = '0;
    cur_w       = SRC_DIM_RESET;
    cur_h       = SRC_DIM_RESET;
    cur_x       = '0;
    cur_y       = '0;
    cur_inv     = INV_SCALE_RESET;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // fill the low store entries; shade items below read only from them
    idle_pct = 13;
    for (int a = 0; a < FILL_DEPTH; a++) load_texel(a, $urandom);

    load_texel(0, 32'hFFFF_FFFF);
    shade_pixel(0, 0);

    apply_setting(8'd32, 8'd16, 17'h0, 17'h0, 16'd256);
    load_texel(FILL_DEPTH - 1, 32'h80FF_0001);
    shade_pixel(31, 15);
    shade_pixel(32, 0);
    shade_pixel(0, 16);
    shade_pixel(4095, 4095);

    apply_setting(8'd32, 8'd16, 17'h0, 17'h0, 16'd512);
    load_texel(1, 32'hFFFF_FFFF);
    load_texel(32, 32'hFFFF_FFFF);
    load_texel(33, 32'h0102_0304);
    shade_pixel(0, 0);
    shade_pixel(15, 7);
    shade_pixel(16, 0);

    apply_setting(8'd128, 8'd128, 17'h0, 17'h0, 16'd0);
    shade_pixel(100, 100);
    shade_pixel(4095, 0);

    apply_setting(8'd0, 8'd128, 17'h0, 17'h0, 16'd256);
    shade_pixel(5, 5);

    apply_setting(8'd255, 8'd4, 17'h0, 17'h0, 16'd256);
    shade_pixel(127, 3);
    shade_pixel(128, 4);

    apply_setting(8'd4, 8'd255, 17'h0, 17'h0, 16'd256);
    shade_pixel(3, 127);
    shade_pixel(4, 128);

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      idle_pct = (s < 3) ? 13 : ((s < 6) ? 88 : 0);
      rx = int'($urandom_range(30000)) - 2000;
      ry = int'($urandom_range(30000)) - 2000;
      case (s)
        0: apply_setting(8'd32, 8'd16, 17'h0, 17'h0, 16'd256);
        1: apply_setting(8'd1, 8'd1, 17'h0, 17'h0, 16'd256);
        2: apply_setting(8'd0, 8'd77, rx[16:0], ry[16:0], 16'd200);
        3: apply_setting(8'd255, 8'd4, 17'h10000, 17'h0FFFF, 16'hFFFF);
        4: apply_setting(8'($urandom_range(1, 32)), 8'($urandom_range(1, 16)),
                         rx[16:0], ry[16:0], 16'($urandom_range(1, 1023)));
        5: apply_setting(8'($urandom_range(1, 128)), 8'($urandom_range(1, 128)),
                         rx[16:0], ry[16:0], 16'd0);
        6: apply_setting(8'd32, 8'd16, 17'h0, 17'h0, 16'd1);
        7: apply_setting(8'd128, 8'd3, 17'h0FFFF, 17'h10000, 16'd128);
        default: apply_setting(8'($urandom_range(129, 255)), 8'($urandom_range(1, 4)),
                               rx[16:0], ry[16:0], 16'($urandom_range(64, 1024)));
      endcase
      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        if ($urandom_range(99) == 0) wait_results();
        random_item();
      end
    end

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_scaled_sprite_supersample OK");
    end else begin
      $display("tb_scaled_sprite_supersample NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/ssup_pkg.sv
rtl/ssup_front.sv
rtl/ssup_queue.sv
rtl/ssup_back.sv
rtl/scaled_sprite_supersample.sv
dv/ssup_tb_pkg.sv
dv/ssup_checker.sv
dv/tb_scaled_sprite_supersample.sv
